@@ src/mavf_pkg.sv @@
// Package for the moving-average / exponential-smoothing filter.
// Holds shared defaults, register codes, the control FSM type and the smoother request struct.
// No dependencies.
package mavf_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int WLEN_REG_W  = 7;
    localparam int ALPHA_W     = 17;
    localparam int Q16_BITS    = 16;

    localparam logic [ALPHA_W-1:0] ONE_Q16  = 17'h10000;
    localparam logic [ALPHA_W-1:0] HALF_Q16 = 17'h08000;

    localparam logic MODE_MAVG   = 1'b0;
    localparam logic MODE_SMOOTH = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FILTER_MODE      = 2'd0,
        REG_WINDOW_LENGTH    = 2'd1,
        REG_SMOOTHING_FACTOR = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic               valid;
        logic               first;
        logic [ALPHA_W-1:0] alpha;
    } smooth_req_t;

endpackage

@@ src/mavf_dline_ram.sv @@
// Delay-line memory: one write port and one read port, registered read data.
// Depends on nothing.
module mavf_dline_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/mavf_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing.
module mavf_div #(
    parameter int NUM_W = 23,
    parameter int DEN_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DEN_W:0]   rem_shift;
    logic             ge;
    logic [DEN_W:0]   rem_sub;

    always_comb begin
        rem_shift = {rem_reg, num_reg[NUM_W-1]};
        ge        = rem_shift >= {1'b0, den_reg};
        rem_sub   = rem_shift - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && cnt_reg == CNT_W'(1)) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            cnt_reg <= CNT_W'(NUM_W);
        end else if (busy_reg) begin
            rem_reg <= ge ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            num_reg <= {num_reg[NUM_W-2:0], ge};
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    assign busy = busy_reg;
    assign quot = num_reg;

endmodule

@@ src/mavf_smooth.sv @@
// First-order exponential smoother with a Q16 fractional accumulator.
// Depends on mavf_pkg.
module mavf_smooth #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mavf_pkg::smooth_req_t         req,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [SAMPLE_BITS-1:0] smoothed
);
    import mavf_pkg::*;

    localparam int ACC_W = SAMPLE_BITS + Q16_BITS;
    localparam int D_W   = ACC_W + 1;
    localparam int P_W   = D_W + ALPHA_W + 1;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [D_W-1:0]   diff_reg;
    logic        [ALPHA_W-1:0] alpha_reg;
    logic signed [P_W-1:0]   prod_reg;
    logic        [1:0]       stage_reg;
    logic signed [ACC_W-1:0] sample_q16;
    logic signed [P_W-1:0]   prod_rnd;
    logic signed [ACC_W:0]   acc_rnd;

    always_comb begin
        sample_q16 = signed'({sample, {Q16_BITS{1'b0}}});
        prod_rnd   = prod_reg + P_W'(HALF_Q16);
        acc_rnd    = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(HALF_Q16);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= '0;
            acc_reg   <= '0;
        end else begin
            stage_reg <= {stage_reg[0], req.valid && !req.first};
            if (req.valid && req.first) begin
                acc_reg <= sample_q16;
            end else if (stage_reg[1]) begin
                acc_reg <= acc_reg + ACC_W'(prod_rnd >>> Q16_BITS);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.valid) begin
            diff_reg  <= D_W'(sample_q16) - D_W'(acc_reg);
            alpha_reg <= req.alpha;
        end
        if (stage_reg[0]) begin
            prod_reg <= signed'({1'b0, alpha_reg}) * diff_reg;
        end
    end

    assign smoothed = acc_rnd[SAMPLE_BITS+Q16_BITS-1:Q16_BITS];

endmodule

@@ src/moving_average_or_first_order_filter.sv @@
// Top level of the moving-average / exponential-smoothing stream filter.
// Depends on mavf_pkg, mavf_dline_ram, mavf_div and mavf_smooth.
//
// One filtered sample leaves for every sample taken, and one request is
// worked on at a time. The next request can be taken in the same cycle
// that the result becomes valid. A request sums n delay-line entries
// (the window length, or fewer early in a record) and then runs the
// serial divider over NUM_W = SAMPLE_BITS + clog2(WINDOW_MAX) + 1 bits.
// The single read port of the delay-line memory sets the summing time,
// the one-bit-per-cycle divider the rest. A result left waiting on
// m_tready holds the following request until it is taken. Both filters
// update on every sample; filter_mode only picks which one drives the
// output.
module moving_average_or_first_order_filter #(
    parameter int WINDOW_MAX  = mavf_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = mavf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_tdata,   // sample
    input  logic                                  s_tuser,   // start_of_record
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,   // filtered
    input  logic                                  cfg_wr_en,
    input  logic [mavf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mavf_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import mavf_pkg::*;

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int PTR_W   = $clog2(WINDOW_MAX);
    localparam int WLEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_MAX);
    localparam int NUM_W   = SUM_W + 1;
    localparam int DEN_W   = WLEN_W + 1;

    state_t state_reg, state_next;

    logic                   mode_reg;
    logic [WLEN_REG_W-1:0]  wlen_reg;
    logic [ALPHA_W-1:0]     alpha_reg;

    logic [PTR_W-1:0]       wp_reg;
    logic [WLEN_W-1:0]      filled_reg;
    logic [WLEN_W-1:0]      n_reg;
    logic [WLEN_W-1:0]      issue_cnt_reg;
    logic [PTR_W-1:0]       rd_addr_reg;
    logic                   rd_vld_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic                   neg_reg;
    logic                   m_tvalid_reg;
    logic [SAMPLE_BITS-1:0] m_tdata_reg;

    logic                   take;
    logic                   rd_en;
    logic                   div_start;
    logic                   out_load;

    logic signed [SAMPLE_BITS-1:0] sample;
    logic [31:0]            wlen_ext;
    logic [WLEN_W-1:0]      w_eff;
    logic [WLEN_W-1:0]      filled_eff;
    logic [WLEN_W-1:0]      filled_new;
    logic [WLEN_W-1:0]      n_calc;
    logic [PTR_W-1:0]       wp_inc;
    logic [PTR_W-1:0]       rd_addr_dec;
    logic [ALPHA_W-1:0]     alpha_sat;
    logic [SUM_W-1:0]       sum_mag;
    logic [NUM_W-1:0]       div_num;
    logic [DEN_W-1:0]       div_den;
    logic                   div_busy;
    logic [NUM_W-1:0]       div_quot;
    logic [NUM_W-1:0]       q_signed;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic signed [SAMPLE_BITS-1:0] smoothed;
    smooth_req_t            smooth_req;

    assign sample = s_tdata[SAMPLE_BITS-1:0];

    always_comb begin
        wlen_ext = 32'(wlen_reg);
        if (wlen_ext == 32'd0) begin
            w_eff = WLEN_W'(1);
        end else if (wlen_ext > 32'(WINDOW_MAX)) begin
            w_eff = WLEN_W'(WINDOW_MAX);
        end else begin
            w_eff = WLEN_W'(wlen_reg);
        end
        filled_eff = s_tuser ? '0 : filled_reg;
        filled_new = (filled_eff == WLEN_W'(WINDOW_MAX)) ? filled_eff
                                                          : filled_eff + WLEN_W'(1);
        n_calc      = (w_eff < filled_new) ? w_eff : filled_new;
        wp_inc      = (wp_reg == PTR_W'(WINDOW_MAX - 1)) ? '0 : wp_reg + PTR_W'(1);
        rd_addr_dec = (rd_addr_reg == '0) ? PTR_W'(WINDOW_MAX - 1)
                                          : rd_addr_reg - PTR_W'(1);
        alpha_sat   = (alpha_reg > ONE_Q16) ? ONE_Q16 : alpha_reg;
        sum_mag     = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        div_num     = {sum_mag, 1'b0} + NUM_W'(w_eff);
        div_den     = {w_eff, 1'b0};
        q_signed    = neg_reg ? (~div_quot + NUM_W'(1)) : div_quot;
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_SUM;
            end
            ST_SUM: begin
                if (issue_cnt_reg == n_reg && !rd_vld_reg) state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!div_busy) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // FSM outputs.
    always_comb begin
        s_tready  = 1'b0;
        take      = 1'b0;
        rd_en     = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                take     = s_tvalid;
            end
            ST_SUM: begin
                rd_en     = issue_cnt_reg != n_reg;
                div_start = issue_cnt_reg == n_reg && !rd_vld_reg;
            end
            ST_DIV: begin
            end
            ST_OUT: begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_MAVG;
            wlen_reg     <= WLEN_REG_W'(1);
            alpha_reg    <= ONE_Q16;
            wp_reg       <= '0;
            filled_reg   <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_en;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FILTER_MODE:      mode_reg  <= cfg_wdata[0];
                    REG_WINDOW_LENGTH:    wlen_reg  <= cfg_wdata[WLEN_REG_W-1:0];
                    REG_SMOOTHING_FACTOR: alpha_reg <= cfg_wdata[ALPHA_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (take) begin
                wp_reg     <= wp_inc;
                filled_reg <= filled_new;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            n_reg         <= n_calc;
            issue_cnt_reg <= '0;
            rd_addr_reg   <= wp_reg;
            sum_reg       <= '0;
        end else begin
            if (rd_en) begin
                rd_addr_reg   <= rd_addr_dec;
                issue_cnt_reg <= issue_cnt_reg + WLEN_W'(1);
            end
            if (rd_vld_reg) begin
                sum_reg <= sum_reg + SUM_W'(signed'(rd_data));
            end
        end
        if (div_start) begin
            neg_reg <= sum_reg[SUM_W-1];
        end
        if (out_load) begin
            m_tdata_reg <= (mode_reg == MODE_SMOOTH) ? smoothed
                                                     : q_signed[SAMPLE_BITS-1:0];
        end
    end

    assign smooth_req = '{valid: take, first: (filled_eff == '0), alpha: alpha_sat};

    mavf_dline_ram #(
        .DEPTH (WINDOW_MAX),
        .WIDTH (SAMPLE_BITS)
    ) u_dline (
        .aclk    (aclk),
        .wr_en   (take),
        .wr_addr (wp_reg),
        .wr_data (sample),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_reg),
        .rd_data (rd_data)
    );

    mavf_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    mavf_smooth #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_smooth (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (smooth_req),
        .sample   (sample),
        .smoothed (smoothed)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(m_tdata_reg);

    a_accept_to_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_SUM))
        else $error("accepted request did not start the window sum");

    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM) |-> (issue_cnt_reg <= n_reg && n_reg != '0))
        else $error("delay-line reads overran the window");

    a_div_done_at_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |-> !div_busy)
        else $error("result loaded while divider still busy");

    a_filled_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg <= WLEN_W'(WINDOW_MAX))
        else $error("filled count above window maximum");

endmodule
